### rtl/lts_pkg.sv
// Shared types and constants of the lower-triangular forward solver.
package lts_pkg;

	// Defaults of the top-level parameters
	localparam int MAX_EQUATIONS_DEF = 16;
	localparam int FRACTION_BITS_DEF = 16;

	// Field widths
	localparam int IDX_W  = 4;
	localparam int COEF_W = 16;
	localparam int VAL_W  = 48;
	localparam int SUM_W  = 64;
	localparam int SIZE_W = 5;

	// Stream words
	localparam int IN_W   = 40;
	localparam int OUT_W  = 56;
	localparam int USER_W = 2;

	// Configuration port
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_ADDR_W-3:0] REG_SYSTEM_SIZE = '0;
	localparam logic [SIZE_W-1:0] SYSTEM_SIZE_RESET = 5'd16;

	// Divider: quotient bits produced per cycle
	localparam int DIV_STEP_BITS = 4;
	localparam int DIV_STEPS     = SUM_W / DIV_STEP_BITS;

	// Value limits
	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
	localparam logic [SUM_W-1:0] VAL_POS_MAG = {{(SUM_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
	localparam logic [SUM_W-1:0] VAL_NEG_MAG = {{(SUM_W-VAL_W){1'b0}}, 1'b1,
		{(VAL_W-1){1'b0}}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_NUM,
		ST_MAG,
		ST_DIV,
		ST_OUT
	} state_t;

endpackage

### rtl/lower_triangular_forward_solve.sv
// Forward substitution, one coefficient word at a time, solutions in Q31.16.
// Below-diagonal word: store read, multiply, saturating accumulate, in that order.
// Diagonal word: numerator, magnitude, 16 radix-16 divider steps and clamp, then the result
// word is registered from ST_OUT; a zero diagonal goes from numerator straight to ST_OUT.
// Ignored words are dropped on acceptance. One word in flight; a stalled output holds ST_OUT.
// Reset clears control and the running sum and sets system_size to 16; the solution store is not cleared.
module lower_triangular_forward_solve #(
	parameter int MAX_EQUATIONS = lts_pkg::MAX_EQUATIONS_DEF,
	parameter int FRACTION_BITS = lts_pkg::FRACTION_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// s_tdata: row_index[3:0], column_index[7:4], coefficient[23:8], right_hand_side[39:24]
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [lts_pkg::IN_W-1:0]        s_tdata,
	// m_tdata: solution_row[3:0], solution_value[51:4], zero[55:52]
	// m_tuser: divide_by_zero[0], saturated[1]
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [lts_pkg::OUT_W-1:0]       m_tdata,
	output logic [lts_pkg::USER_W-1:0]      m_tuser,
	output logic                            m_tlast,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lts_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [lts_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [lts_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                            pready
);
	import lts_pkg::*;

	localparam int AW = (MAX_EQUATIONS > 1) ? $clog2(MAX_EQUATIONS) : 1;

	state_t state_q, state_n;

	// configuration
	logic [SIZE_W-1:0] system_size_q;
	logic              cfg_wr;

	// input decode
	logic              s_accept;
	logic [IDX_W-1:0]  row_in, col_in;
	logic              ignore_in;

	// captured word
	logic [IDX_W-1:0]         row_q;
	logic signed [COEF_W-1:0] coef_q;
	logic signed [COEF_W-1:0] rhs_q;

	// accumulation
	logic signed [SUM_W-1:0] sum_q;
	logic                    sum_sat_q;
	logic signed [SUM_W-1:0] prod_c, prod_s1;
	logic [SUM_W:0]          acc_ext;
	logic                    acc_ovf;

	// diagonal
	logic signed [SUM_W-1:0] bs_c;
	logic [SUM_W:0]          num_ext;
	logic                    num_ovf;
	logic signed [SUM_W-1:0] num_q;
	logic                    neg_q;
	logic                    flag_q;
	logic                    dz_q;
	logic signed [VAL_W-1:0] value_q;
	logic [SUM_W-1:0]        un_c;
	logic [COEF_W-1:0]       ud_c;
	logic                    div_start, div_done;
	logic [SUM_W-1:0]        quot;
	logic                    q_ovf;
	logic [SUM_W-1:0]        q_clamped;

	// store
	logic                    st_wr, st_rd;
	logic signed [VAL_W-1:0] st_rdata;

	// output register
	logic                    m_valid_q;
	logic [IDX_W-1:0]        m_row_q;
	logic signed [VAL_W-1:0] m_value_q;
	logic                    m_dz_q, m_sat_q, m_last_q;
	logic                    out_free;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[CFG_ADDR_W-1:2] == REG_SYSTEM_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			system_size_q <= SYSTEM_SIZE_RESET;
		end else if (cfg_wr) begin
			system_size_q <= pwdata[SIZE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[CFG_ADDR_W-1:2] == REG_SYSTEM_SIZE) begin
			prdata = CFG_DATA_W'(system_size_q);
		end
	end

	// ---------------- input decode ----------------
	assign row_in    = s_tdata[3:0];
	assign col_in    = s_tdata[7:4];
	assign ignore_in = (32'(row_in) >= MAX_EQUATIONS) || (32'(col_in) >= MAX_EQUATIONS)
		|| (col_in > row_in);
	assign s_accept  = s_tvalid && s_tready;
	assign out_free  = !m_valid_q || m_tready;

	// ---------------- state machine ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_accept && !ignore_in) begin
					state_n = (col_in < row_in) ? ST_MUL : ST_NUM;
				end
			end
			ST_MUL: state_n = ST_ACC;
			ST_ACC: state_n = ST_IDLE;
			ST_NUM: state_n = (coef_q == '0) ? ST_OUT : ST_MAG;
			ST_MAG: state_n = ST_DIV;
			ST_DIV: begin
				if (div_done) begin
					state_n = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		st_rd     = 1'b0;
		st_wr     = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				st_rd    = s_accept;
			end
			ST_MAG: div_start = 1'b1;
			ST_OUT: st_wr = out_free;
			ST_MUL, ST_ACC, ST_NUM, ST_DIV: ;
			default: ;
		endcase
	end

	// ---------------- datapath ----------------
	assign prod_c  = SUM_W'(coef_q) * SUM_W'(st_rdata);
	assign acc_ext = {sum_q[SUM_W-1], sum_q} + {prod_s1[SUM_W-1], prod_s1};
	assign acc_ovf = acc_ext[SUM_W] != acc_ext[SUM_W-1];

	assign bs_c    = SUM_W'(rhs_q) <<< FRACTION_BITS;
	assign num_ext = {bs_c[SUM_W-1], bs_c} - {sum_q[SUM_W-1], sum_q};
	assign num_ovf = num_ext[SUM_W] != num_ext[SUM_W-1];

	assign un_c = num_q[SUM_W-1] ? (SUM_W'(0) - num_q) : num_q;
	assign ud_c = coef_q[COEF_W-1] ? (COEF_W'(0) - coef_q) : coef_q;

	// negative results may reach -2^47, positive ones only 2^47-1
	assign q_ovf     = neg_q ? (quot > VAL_NEG_MAG) : (quot > VAL_POS_MAG);
	assign q_clamped = q_ovf ? (neg_q ? VAL_NEG_MAG : VAL_POS_MAG) : quot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q     <= '0;
			sum_sat_q <= 1'b0;
		end else if (s_accept && !ignore_in && (col_in == '0)) begin
			sum_q     <= '0;
			sum_sat_q <= 1'b0;
		end else if (state_q == ST_ACC) begin
			sum_q     <= acc_ovf ? (acc_ext[SUM_W] ? SUM_MIN : SUM_MAX) : acc_ext[SUM_W-1:0];
			sum_sat_q <= sum_sat_q | acc_ovf;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			row_q  <= row_in;
			coef_q <= s_tdata[23:8];
			rhs_q  <= s_tdata[39:24];
		end
		if (state_q == ST_MUL) begin
			prod_s1 <= prod_c;
		end
		if (state_q == ST_NUM) begin
			dz_q    <= (coef_q == '0);
			value_q <= '0;
			num_q   <= num_ovf ? (num_ext[SUM_W] ? SUM_MIN : SUM_MAX) : num_ext[SUM_W-1:0];
			flag_q  <= sum_sat_q | ((coef_q != '0) && num_ovf);
		end
		if (state_q == ST_MAG) begin
			neg_q <= num_q[SUM_W-1] ^ coef_q[COEF_W-1];
		end
		if ((state_q == ST_DIV) && div_done) begin
			value_q <= neg_q ? VAL_W'(SUM_W'(0) - q_clamped) : VAL_W'(q_clamped);
			flag_q  <= flag_q | q_ovf;
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (st_wr) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_wr) begin
			m_row_q   <= row_q;
			m_value_q <= value_q;
			m_dz_q    <= dz_q;
			m_sat_q   <= flag_q;
			m_last_q  <= (SIZE_W'(row_q) + 1'b1) == system_size_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(OUT_W-VAL_W-IDX_W){1'b0}}, m_value_q, m_row_q};
	assign m_tuser  = {m_sat_q, m_dz_q};
	assign m_tlast  = m_last_q;

	// ---------------- units ----------------
	lts_store #(
		.DEPTH (MAX_EQUATIONS),
		.AW    (AW),
		.W     (VAL_W)
	) u_store (
		.clk     (clk),
		.wr_en   (st_wr),
		.wr_addr (AW'(row_q)),
		.wr_data (value_q),
		.rd_en   (st_rd),
		.rd_addr (AW'(col_in)),
		.rd_data (st_rdata)
	);

	lts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (un_c),
		.divisor  (ud_c),
		.done     (div_done),
		.quotient (quot)
	);

endmodule

### rtl/lts_store.sv
// Solution memory: one write port, one read port, registered read data.
module lts_store #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int W     = 48
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  logic signed [W-1:0] wr_data,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	output logic signed [W-1:0] rd_data
);

	logic signed [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/lts_div.sv
// Iterative unsigned divider, 64-bit dividend by 16-bit divisor, several bits a cycle.
module lts_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [lts_pkg::SUM_W-1:0]   dividend,
	input  logic [lts_pkg::COEF_W-1:0]  divisor,
	output logic                        done,
	output logic [lts_pkg::SUM_W-1:0]   quotient
);
	import lts_pkg::*;

	localparam int CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] dvd_q;    // dividend shifts out the top, quotient in at the bottom
	logic [COEF_W:0]  rem_q;
	logic [COEF_W-1:0] dvs_q;
	logic [SUM_W-1:0] dvd_n;
	logic [COEF_W:0]  rem_n;

	always_comb begin
		logic [COEF_W:0]  r;
		logic [SUM_W-1:0] d;
		r = rem_q;
		d = dvd_q;
		for (int k = 0; k < DIV_STEP_BITS; k++) begin
			r = {r[COEF_W-1:0], d[SUM_W-1]};
			d = {d[SUM_W-2:0], 1'b0};
			if (r >= {1'b0, dvs_q}) begin
				r = r - {1'b0, dvs_q};
				d[0] = 1'b1;
			end
		end
		rem_n = r;
		dvd_n = d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_n;
			rem_q <= rem_n;
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

### tb/testbench.sv
// Self-checking testbench for the lower-triangular forward solver.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import lts_pkg::*;

	localparam int FRAC = FRACTION_BITS_DEF;
	localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint ACC_MIN = 64'sh8000_0000_0000_0000;
	localparam logic [63:0] POS_LIM = 64'h0000_7FFF_FFFF_FFFF;
	localparam logic [63:0] NEG_LIM = 64'h0000_8000_0000_0000;
	localparam logic [CFG_ADDR_W-3:0] REG_SPARE = 1'b1;
	localparam int DRAIN = 30;
	localparam int LIMIT = 1_000_000;

	// tdata word: row[3:0], column[7:4], coefficient[23:8], right-hand side[39:24]
	typedef struct packed {
		logic signed [15:0] rhs;
		logic signed [15:0] coef;
		logic [3:0] col;
		logic [3:0] row;
	} word_t;

	typedef struct packed {
		logic [3:0] row;
		logic [47:0] value;
		logic dz;
		logic sat;
		logic last;
	} sol_t;

	typedef struct packed {
		logic [3:0] row;
		logic [3:0] col;
		logic signed [15:0] coef;
		logic signed [15:0] rhs;
		logic fixed;
		logic [47:0] value;
		logic dz;
		logic sat;
		logic last;
	} plan_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;     // row[3:0], value[51:4]
	logic [USER_W-1:0] m_tuser;    // divide_by_zero[0], saturated[1]
	logic m_tlast;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic pready;

	lower_triangular_forward_solve dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// solver state as seen from outside
	longint x_store [16];
	longint acc = 0;
	bit acc_sat = 1'b0;
	logic [4:0] size_reg = SYSTEM_SIZE_RESET;
	bit written [16];

	sol_t sol_q [$];
	int errors = 0;
	int cycles = 0;
	int stall_left = 0;
	bit calm = 1'b0;

	// Directed words; rows with fixed set carry a hand-computed solution.
	plan_t plan [23] = '{
		'{0, 0, 1, 32767, 1, 48'h0000_7FFF_0000, 0, 0, 0},
		'{1, 0, -32768, 0, 0, 0, 0, 0, 0},
		'{1, 1, 1, 32767, 0, 0, 0, 0, 0},
		'{2, 0, 0, 0, 0, 0, 0, 0, 0},
		'{2, 1, -32768, 0, 0, 0, 0, 0, 0},
		'{2, 2, 1, -32768, 1, 48'h7FFF_FFFF_FFFF, 0, 1, 0},  // quotient clamps high
		'{3, 0, 0, 0, 0, 0, 0, 0, 0},
		'{3, 2, 32767, 0, 0, 0, 0, 0, 0},
		'{3, 2, 32767, 0, 0, 0, 0, 0, 0},
		'{3, 2, 32767, 0, 0, 0, 0, 0, 0},                  // sum saturates
		'{3, 3, 0, 5, 1, 48'h0, 1, 1, 0},                   // zero diagonal
		'{4, 0, 0, 0, 0, 0, 0, 0, 0},
		'{4, 2, -32768, 0, 0, 0, 0, 0, 0},
		'{4, 2, -32768, 0, 0, 0, 0, 0, 0},
		'{4, 4, 1, 32767, 1, 48'h7FFF_FFFF_FFFF, 0, 1, 0},  // numerator overflow
		'{5, 0, 0, 0, 0, 0, 0, 0, 0},
		'{5, 2, 32767, 0, 0, 0, 0, 0, 0},
		'{5, 5, 1, -32768, 1, 48'h8000_0000_0000, 0, 1, 0}, // quotient clamps low
		'{6, 0, 3, 100, 0, 0, 0, 0, 0},
		'{6, 6, -7, -100, 0, 0, 0, 0, 0},
		'{7, 7, 3, -1, 0, 0, 0, 0, 0},                      // sum carried over
		'{0, 15, 5, 5, 0, 0, 0, 0, 0},                      // above diagonal
		'{15, 15, -1, -1, 0, 0, 0, 0, 0}
	};

	function automatic bit solve_word(input word_t w, output sol_t s);
		longint prod, sum, bs, num, val;
		logic [63:0] mag, div, quo;
		bit sat, neg;
		s = '0;
		if (w.col > w.row)
			return 1'b0;
		if (w.col == 0) begin
			acc = 0;
			acc_sat = 1'b0;
		end
		if (w.col < w.row) begin
			prod = longint'(w.coef) * x_store[w.col];
			sum = acc + prod;
			if (acc[63] == prod[63] && sum[63] != acc[63]) begin
				acc_sat = 1'b1;
				sum = acc[63] ? ACC_MIN : ACC_MAX;
			end
			acc = sum;
			return 1'b0;
		end
		sat = acc_sat;
		val = 0;
		if (w.coef == 0) begin
			s.dz = 1'b1;
		end else begin
			bs = longint'(w.rhs) <<< FRAC;
			num = bs - acc;
			if (bs[63] != acc[63] && num[63] != bs[63]) begin
				sat = 1'b1;
				num = bs[63] ? ACC_MIN : ACC_MAX;
			end
			mag = num[63] ? 64'(-num) : 64'(num);
			div = w.coef[15] ? 64'(-longint'(w.coef)) : 64'(longint'(w.coef));
			quo = mag / div;
			neg = num[63] ^ w.coef[15];
			if (neg) begin
				if (quo > NEG_LIM) begin
					quo = NEG_LIM;
					sat = 1'b1;
				end
				val = -longint'(quo);
			end else begin
				if (quo > POS_LIM) begin
					quo = POS_LIM;
					sat = 1'b1;
				end
				val = longint'(quo);
			end
		end
		x_store[w.row] = val;
		s.row = w.row;
		s.value = val[47:0];
		s.sat = sat;
		s.last = (size_reg != 0) && ({1'b0, w.row} == size_reg - 5'd1);
		return 1'b1;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [15:0] pick_coef(input bit diag);
		int r;
		int v;
		r = $urandom_range(0, 19);
		v = $urandom_range(1, 3);
		if (diag) begin
			if (r == 0)
				return 16'sd0;
			if (r < 10)
				return 16'($urandom_range(0, 1) ? -v : v);
			return 16'($urandom);
		end
		if (r < 8)
			return 16'($urandom);
		if (r < 13)
			return 16'(int'($urandom_range(0, 8)) - 4);
		if (r < 15)
			return -16'sd32768;
		if (r < 17)
			return 16'sd32767;
		return 16'sd0;
	endfunction

	function automatic logic signed [15:0] pick_rhs();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return $urandom_range(0, 1) ? -16'sd32768 : 16'sd32767;
		if (r < 4)
			return 16'(int'($urandom_range(0, 20)) - 10);
		return 16'($urandom);
	endfunction

	task automatic flag(input string msg);
		errors++;
		if (errors <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	task automatic send_word(input word_t w, input bit fixed, input sol_t fixed_sol);
		int gap;
		sol_t s;
		gap = calm ? 0 : gap_len();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= w;
		do @(posedge clk); while (!s_tready);
		if (w.col == w.row)
			written[w.row] = 1'b1;
		if (solve_word(w, s))
			sol_q.push_back(fixed ? fixed_sol : s);
	endtask

	task automatic apb_access(input logic [CFG_ADDR_W-3:0] idx, input bit wr,
			input logic [31:0] data, output logic [31:0] rd);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (wr && idx == REG_SYSTEM_SIZE)
			size_reg = data[4:0];
		@(posedge clk);
	endtask

	task automatic set_size(input logic [31:0] value);
		logic [31:0] rd;
		apb_access(REG_SYSTEM_SIZE, 1'b1, value, rd);
		apb_access(REG_SYSTEM_SIZE, 1'b0, '0, rd);
		if (rd !== {27'b0, size_reg})
			flag($sformatf("system_size readback: expected %0d, got %h", size_reg, rd));
	endtask

	// no results in flight, then let ignored or below-diagonal words settle
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sol_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic random_items(input int count);
		int done;
		int n;
		word_t w;
		done = 0;
		while (done < count) begin
			if ($urandom_range(0, 9) < 8) begin
				// whole system, rows in order
				n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
				for (int i = 0; i < n; i++) begin
					w.rhs = pick_rhs();
					for (int j = 0; j <= i; j++) begin
						w.row = 4'(i);
						w.col = 4'(j);
						w.coef = pick_coef(j == i);
						send_word(w, 1'b0, '0);
						done++;
					end
				end
			end else begin
				// stray word: out of order, above diagonal or mid-row
				w.row = 4'($urandom_range(0, 15));
				w.col = 4'($urandom_range(0, 15));
				w.coef = pick_coef(1'($urandom_range(0, 1)));
				w.rhs = pick_rhs();
				if (w.col < w.row && !written[w.col])
					w.col = w.row;
				send_word(w, 1'b0, '0);
				if (w.col <= w.row)
					done++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!calm && $urandom_range(0, 4) == 0) begin
			m_tready <= 1'b0;
			stall_left <= gap_len();
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		sol_t got;
		sol_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.row = m_tdata[3:0];
			got.value = m_tdata[51:4];
			got.dz = m_tuser[0];
			got.sat = m_tuser[1];
			got.last = m_tlast;
			if (sol_q.size() == 0) begin
				flag($sformatf("unexpected word: row %0d value %h", got.row, got.value));
			end else begin
				want = sol_q.pop_front();
				if (got.row !== want.row || got.value !== want.value || got.dz !== want.dz ||
						got.sat !== want.sat || got.last !== want.last)
					flag($sformatf({"expected row %0d value %h dz %b sat %b last %b, ",
						"got row %0d value %h dz %b sat %b last %b"},
						want.row, want.value, want.dz, want.sat, want.last,
						got.row, got.value, got.dz, got.sat, got.last));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	initial begin
		word_t w;
		sol_t fs;
		logic [31:0] rd;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part runs with system_size at its reset value
		foreach (plan[k]) begin
			w.row = plan[k].row;
			w.col = plan[k].col;
			w.coef = plan[k].coef;
			w.rhs = plan[k].rhs;
			fs = '{plan[k].row, plan[k].value, plan[k].dz, plan[k].sat, plan[k].last};
			send_word(w, plan[k].fixed, fs);
		end

		for (int ph = 0; ph < 8; ph++) begin
			wait_idle();
			calm = (ph % 3 == 2);
			case (ph)
				0: set_size(32'd1);
				1: set_size(32'd16);
				2: set_size(32'd0);
				3: begin
					set_size(32'd9);
					apb_access(REG_SPARE, 1'b1, 32'd3, rd);   // unused index, no effect
				end
				default: set_size($urandom_range(1, 16));
			endcase
			random_items(180);
		end
		wait_idle();

		if (errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

### lower_triangular_forward_solve.f
rtl/lts_pkg.sv
rtl/lts_store.sv
rtl/lts_div.sv
rtl/lower_triangular_forward_solve.sv
tb/testbench.sv
